// ----- design/dcpt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcpt_pkg
// Shared widths, constants and handshake structs for the divisor count
// primality tester.
// ----------------------------------------------------------------------------
package dcpt_pkg;

    localparam int VALUE_WIDTH   = 16;
    localparam int CAND_W        = 16;
    localparam int COUNT_W       = 8;
    localparam int COUNT_MAX     = 255;
    localparam int PRIME_DIVS    = 2;
    localparam int CNT_W         = VALUE_WIDTH / 2 + 2;
    localparam int SQ_W          = VALUE_WIDTH + 2;
    localparam int ITER_W        = $clog2(VALUE_WIDTH + 1);

    typedef struct packed {
        logic                   start;
        logic [VALUE_WIDTH-1:0] dividend;
        logic [VALUE_WIDTH-1:0] divisor;
    } t_rem_req;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_rem_rsp;

endpackage

// ----- design/dcpt_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcpt_in_if
// Candidate channel: valid/ready handshake carrying one value to test.
// ----------------------------------------------------------------------------
interface dcpt_in_if;
    import dcpt_pkg::*;

    logic              valid;
    logic              ready;
    logic [CAND_W-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

// ----- design/dcpt_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcpt_out_if
// Result channel: valid/ready handshake carrying value, divisor count, flag.
// ----------------------------------------------------------------------------
interface dcpt_out_if;
    import dcpt_pkg::*;

    logic               valid;
    logic               ready;
    logic [CAND_W-1:0]  tested_value;
    logic [COUNT_W-1:0] divisor_count;
    logic               is_prime;

    modport source (output valid, output tested_value, output divisor_count,
                    output is_prime, input ready);
    modport sink   (input valid, input tested_value, input divisor_count,
                    input is_prime, output ready);
endinterface

// ----- design/dcpt_rem_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcpt_rem_unit
// Bit-serial restoring remainder unit: one dividend bit per cycle, reports
// whether the remainder is zero.
// ----------------------------------------------------------------------------
module dcpt_rem_unit
    import dcpt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_rem_req i_req,
    output t_rem_rsp o_rsp
);

    logic                   r_busy;
    logic                   r_done;
    logic [ITER_W-1:0]      r_left;
    logic [VALUE_WIDTH-1:0] r_rem;
    logic [VALUE_WIDTH-1:0] r_dvd;
    logic [VALUE_WIDTH-1:0] r_dsr;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   diff;

    assign trial = {r_rem, r_dvd[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_left <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_left <= ITER_W'(VALUE_WIDTH);
                r_rem  <= '0;
                r_dvd  <= i_req.dividend;
                r_dsr  <= i_req.divisor;
            end else if (r_busy) begin
                r_dvd  <= {r_dvd[VALUE_WIDTH-2:0], 1'b0};
                if (trial >= {1'b0, r_dsr}) begin
                    r_rem <= diff[VALUE_WIDTH-1:0];
                end else begin
                    r_rem <= trial[VALUE_WIDTH-1:0];
                end
                r_left <= r_left - ITER_W'(1);
                if (r_left == ITER_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.rem_zero = (r_rem == '0);

endmodule

// ----- design/divisor_count_prime_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// divisor_count_prime_test
// Counts the divisors of a candidate by trial division and flags primes.
//
// i_cand carries one candidate per beat; o_res returns one beat per
// candidate with the value echoed, its divisor count (saturated at 255)
// and a prime flag set when the count is exactly two.
// Trial divisors i run from 1 while i*i <= n; each is tested by a shared
// bit-serial remainder unit started from the check state; the count is
// updated in the divide state when the unit reports done, and the next
// divisor and its square are formed before returning to the check state.
// One candidate is in work at a time: i_cand.ready is high only when idle.
// The result sits in an output register; if the receiver stalls, the next
// candidate is still taken and computed, and the block then waits with
// that result until the output register frees.
// Synchronous reset clears the sequencer and the output valid; no result
// is pending after reset.
// ----------------------------------------------------------------------------
module divisor_count_prime_test
    import dcpt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    dcpt_in_if.sink    i_cand,
    dcpt_out_if.source o_res
);

    typedef enum logic [1:0] {S_IDLE, S_CHECK, S_DIV, S_FIN} t_state;

    t_state                 r_state;
    logic [VALUE_WIDTH-1:0] r_n;
    logic [VALUE_WIDTH-1:0] r_i;
    logic [SQ_W-1:0]        r_sq;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_start;
    logic                   r_out_valid;
    logic [CAND_W-1:0]      r_out_value;
    logic [COUNT_W-1:0]     r_out_count;
    logic                   r_out_prime;
    t_rem_req               rem_req;
    t_rem_rsp               rem_rsp;
    logic                   out_free;
    logic                   saturate;

    assign rem_req.start    = r_start;
    assign rem_req.dividend = r_n;
    assign rem_req.divisor  = r_i;

    dcpt_rem_unit u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rem_req),
        .o_rsp   (rem_rsp)
    );

    assign out_free = !r_out_valid || o_res.ready;
    assign saturate = (32'(r_cnt) > 32'(COUNT_MAX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (r_out_valid && o_res.ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cand.valid) begin
                        r_n     <= VALUE_WIDTH'(i_cand.candidate);
                        r_i     <= VALUE_WIDTH'(1);
                        r_sq    <= SQ_W'(1);
                        r_cnt   <= '0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_sq > SQ_W'(r_n)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_start <= 1'b1;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (rem_rsp.done) begin
                        if (rem_rsp.rem_zero) begin
                            if (r_sq == SQ_W'(r_n)) begin
                                r_cnt <= r_cnt + CNT_W'(1);
                            end else begin
                                r_cnt <= r_cnt + CNT_W'(2);
                            end
                        end
                        r_i     <= r_i + VALUE_WIDTH'(1);
                        r_sq    <= r_sq + SQ_W'({r_i, 1'b1});
                        r_state <= S_CHECK;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= CAND_W'(r_n);
                        r_out_count <= saturate ? COUNT_W'(COUNT_MAX) : COUNT_W'(r_cnt);
                        r_out_prime <= (r_cnt == CNT_W'(PRIME_DIVS));
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_cand.ready        = (r_state == S_IDLE);
    assign o_res.valid         = r_out_valid;
    assign o_res.tested_value  = r_out_value;
    assign o_res.divisor_count = r_out_count;
    assign o_res.is_prime      = r_out_prime;

endmodule

// ----- design/dcpt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcpt_checker
// Port-level checks on the divisor count primality tester.
// ----------------------------------------------------------------------------
module dcpt_checker
    import dcpt_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [CAND_W-1:0]  i_tested_value,
    input logic [COUNT_W-1:0] i_divisor_count,
    input logic               i_is_prime
);

    // stalled result beat must hold
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_tested_value)
            && $stable(i_divisor_count) && $stable(i_is_prime))
        else $error("result beat changed while stalled");

    // one candidate in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("candidate taken while busy");

    // prime flag agrees with the count
    a_prime_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_is_prime == (i_divisor_count == COUNT_W'(PRIME_DIVS))))
        else $error("prime flag does not match divisor count");

    // zero and one have fixed counts
    a_small_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_tested_value == CAND_W'(0) || i_tested_value == CAND_W'(1))
            |-> i_divisor_count == COUNT_W'(i_tested_value))
        else $error("wrong count for zero or one");

endmodule

bind divisor_count_prime_test dcpt_checker u_dcpt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_cand.valid),
    .i_in_ready      (i_cand.ready),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_tested_value  (o_res.tested_value),
    .i_divisor_count (o_res.divisor_count),
    .i_is_prime      (o_res.is_prime)
);
